>>> hdl/power_of_two_page_allocator_unit_defines.svh
// Assertion macros for the page allocator.
// Included by the modules that carry assertions; depends on clk_i and rst_ni in scope.
`ifndef POWER_OF_TWO_PAGE_ALLOCATOR_UNIT_DEFINES_SVH
`define POWER_OF_TWO_PAGE_ALLOCATOR_UNIT_DEFINES_SVH

// A condition that holds at every clock edge out of reset.
`define PPA_ASSERT_HOLD(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error(msg);

// A consequence that holds in the same cycle as its antecedent.
`define PPA_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

>>> hdl/ppa_pkg.sv
// Shared types and constants of the page allocator.
// No dependencies; imported by ppa_piece, ppa_ctrl and the top level.
package ppa_pkg;

  // Default geometry.
  localparam int PAGE_ADDR_BITS_DEF = 10;
  localparam int MAX_ORDER_DEF      = 4;

  // Free maps are stored in rows of 2^ROW_LOG bits.
  localparam int ROW_LOG = 5;
  localparam int ROW_W   = 1 << ROW_LOG;

  // Configuration register.
  localparam int               CFG_W           = 11;
  localparam logic [CFG_W-1:0] TOTAL_PAGES_RST = 11'd1024;

  // Request field widths.
  localparam int SIZE_W = 8;

  typedef enum logic {
    OP_INIT  = 1'b0,
    OP_ALLOC = 1'b1
  } ppa_op_e;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_BAD_SIZE = 2'd1,
    STATUS_NO_SPACE = 2'd2
  } ppa_status_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SRCH_RD,
    ST_SRCH_CHK,
    ST_CARVE_RD,
    ST_CARVE_WR,
    ST_DONE
  } ppa_state_e;

  // Handshake flags from the sequencer to the top level.
  typedef struct packed {
    logic ready;
    logic done;
  } ppa_ctrl_flags_t;

endpackage

>>> hdl/ppa_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies; holds the free-block map rows.
module ppa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> hdl/ppa_piece.sv
// Piece sizer: largest power of two not above a span or the largest block.
// Depends on ppa_pkg; shared by both carving directions in the sequencer.
module ppa_piece
  import ppa_pkg::*;
#(
  parameter int PAGE_ADDR_BITS = PAGE_ADDR_BITS_DEF,
  parameter int MAX_ORDER      = MAX_ORDER_DEF,
  localparam int TOP = (MAX_ORDER < PAGE_ADDR_BITS) ? MAX_ORDER : PAGE_ADDR_BITS,
  localparam int OW  = (TOP > 0) ? $clog2(TOP + 1) : 1,
  localparam int CW  = PAGE_ADDR_BITS + 1
) (
  input  logic [CW-1:0] span_i,
  output logic [OW-1:0] order_o,
  output logic [CW-1:0] size_o
);

  localparam logic [CW-1:0] MAX_BLOCK = CW'(1) << TOP;

  logic [CW-1:0] capped;
  logic [OW-1:0] ord;

  // Cap the span, then find its highest set bit.
  always_comb begin
    capped = (span_i > MAX_BLOCK) ? MAX_BLOCK : span_i;
    ord    = '0;
    for (int i = 0; i < CW; i++) begin
      if (capped[i]) begin
        ord = OW'(i);
      end
    end
  end

  assign order_o = ord;
  assign size_o  = CW'(1) << ord;

endmodule

>>> hdl/ppa_ctrl.sv
// Sequencer and map datapath: clearing pass, carving, and the order-by-order search.
// Depends on ppa_pkg, ppa_ram, ppa_piece and the assertion macro header.
`include "power_of_two_page_allocator_unit_defines.svh"

module ppa_ctrl
  import ppa_pkg::*;
#(
  parameter int PAGE_ADDR_BITS = PAGE_ADDR_BITS_DEF,
  parameter int MAX_ORDER      = MAX_ORDER_DEF,
  localparam int CW = PAGE_ADDR_BITS + 1
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic                      opcode_i,
  input  logic [SIZE_W-1:0]         size_i,
  input  logic [CFG_W-1:0]          total_pages_i,
  input  logic                      slot_free_i,
  output ppa_ctrl_flags_t           flags_o,
  output ppa_status_e               status_o,
  output logic [PAGE_ADDR_BITS-1:0] offset_o,
  output logic [CW-1:0]             free_pages_o
);

  localparam int PA        = PAGE_ADDR_BITS;
  localparam int TOP       = (MAX_ORDER < PA) ? MAX_ORDER : PA;
  localparam int OW        = (TOP > 0) ? $clog2(TOP + 1) : 1;
  localparam int IW        = (PA > ROW_LOG) ? PA : ROW_LOG + 1;
  localparam int RW        = IW - ROW_LOG;
  localparam int AW        = OW + RW;
  localparam int RAM_DEPTH = 1 << AW;
  localparam int ROWS      = 1 << RW;
  localparam int USED_ROWS = (TOP + 1) * ROWS;
  localparam int PAGES     = 1 << PA;
  localparam int MAX_BLOCK = 1 << TOP;

  localparam logic [AW-1:0] CLR_LAST  = AW'(USED_ROWS - 1);
  localparam logic [OW-1:0] TOP_ORD   = OW'(TOP);
  localparam logic [CW-1:0] PAGES_CNT = CW'(PAGES);

  ppa_state_e state_q, state_d;
  logic              init_q, init_d;
  logic [AW-1:0]     clr_q, clr_d;
  logic [CW-1:0]     lo_q, lo_d, hi_q, hi_d;
  logic              left_q, left_d;
  logic [OW-1:0]     ord_q, ord_d;
  logic [RW-1:0]     row_q, row_d;
  logic [SIZE_W-1:0] size_q, size_d;
  logic [AW-1:0]     mark_addr_q, mark_addr_d;
  logic [ROW_LOG-1:0] mark_bit_q, mark_bit_d;
  logic [CW-1:0]     fc_q, fc_d;
  logic [PA-1:0]     off_q, off_d;
  ppa_status_e       status_q, status_d;

  // RAM port signals.
  logic              ram_we;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  logic [ROW_W-1:0]  ram_wdata, ram_rdata;

  // Request decode.
  logic [OW-1:0]     req_ord;
  logic              req_bad;
  logic [CW-1:0]     init_n;

  // Carve step.
  logic [CW-1:0]     span, p_size, pos;
  logic [OW-1:0]     p_ord;
  logic [IW-1:0]     midx;
  logic [AW-1:0]     mark_addr;

  // Search step.
  logic              hit;
  logic [ROW_LOG-1:0] low_bit;
  logic [IW-1:0]     found_idx;
  logic [CW-1:0]     found_off;
  logic [RW-1:0]     last_row;

  ppa_ram #(
    .WIDTH(ROW_W),
    .DEPTH(RAM_DEPTH)
  ) u_map_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  ppa_piece #(
    .PAGE_ADDR_BITS(PAGE_ADDR_BITS),
    .MAX_ORDER     (MAX_ORDER)
  ) u_piece (
    .span_i (span),
    .order_o(p_ord),
    .size_o (p_size)
  );

  // Size check, rounding up to an order, and the saturated init count.
  always_comb begin
    logic [31:0] tp32;
    req_ord = '0;
    for (int i = SIZE_W; i >= 0; i--) begin
      if ((9'd1 << i) >= {1'b0, size_i}) begin
        req_ord = OW'(i);
      end
    end
    req_bad = (size_i == '0) || ({24'b0, size_i} > 32'(MAX_BLOCK));
    tp32    = 32'(total_pages_i);
    init_n  = CW'((tp32 > 32'(PAGES)) ? 32'(PAGES) : tp32);
  end

  // Next piece of the current carve and where its map bit lives.
  always_comb begin
    span      = hi_q - lo_q;
    pos       = left_q ? lo_q : (hi_q - p_size);
    midx      = IW'(pos[PA-1:0] >> p_ord);
    mark_addr = {p_ord, midx[IW-1:ROW_LOG]};
  end

  // Lowest free block in the row just read.
  always_comb begin
    hit     = |ram_rdata;
    low_bit = '0;
    for (int i = ROW_W - 1; i >= 0; i--) begin
      if (ram_rdata[i]) begin
        low_bit = ROW_LOG'(i);
      end
    end
    found_idx = {row_q, low_bit};
    found_off = CW'(found_idx) << ord_q;
    last_row  = {RW{1'b1}} >> ord_q;
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (clr_q == CLR_LAST) begin
          state_d = init_q ? ST_CARVE_RD : ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start_i) begin
          if (opcode_i == OP_INIT) begin
            state_d = ST_CLEAR;
          end else if (req_bad) begin
            state_d = ST_DONE;
          end else begin
            state_d = ST_SRCH_RD;
          end
        end
      end
      ST_SRCH_RD: state_d = ST_SRCH_CHK;
      ST_SRCH_CHK: begin
        if (hit) begin
          state_d = ST_CARVE_RD;
        end else if (row_q == last_row && ord_q == TOP_ORD) begin
          state_d = ST_DONE;
        end else begin
          state_d = ST_SRCH_RD;
        end
      end
      ST_CARVE_RD: state_d = (lo_q < hi_q) ? ST_CARVE_WR : ST_DONE;
      ST_CARVE_WR: state_d = ST_CARVE_RD;
      ST_DONE: begin
        if (slot_free_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // RAM control per state.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = mark_addr_q;
    ram_wdata = ram_rdata;
    ram_raddr = {ord_q, row_q};
    case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = '0;
      end
      ST_SRCH_CHK: begin
        ram_we    = hit;
        ram_waddr = {ord_q, row_q};
        ram_wdata = ram_rdata & ~(ROW_W'(1) << low_bit);
      end
      ST_CARVE_RD: ram_raddr = mark_addr;
      ST_CARVE_WR: begin
        ram_we    = 1'b1;
        ram_wdata = ram_rdata | (ROW_W'(1) << mark_bit_q);
      end
      default: ram_we = 1'b0;
    endcase
  end

  // Datapath register updates.
  always_comb begin
    init_d      = init_q;
    clr_d       = clr_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    left_d      = left_q;
    ord_d       = ord_q;
    row_d       = row_q;
    size_d      = size_q;
    mark_addr_d = mark_addr_q;
    mark_bit_d  = mark_bit_q;
    fc_d        = fc_q;
    off_d       = off_q;
    status_d    = status_q;
    case (state_q)
      ST_CLEAR: clr_d = clr_q + AW'(1);
      ST_IDLE: begin
        if (start_i) begin
          off_d    = '0;
          status_d = STATUS_OK;
          clr_d    = '0;
          if (opcode_i == OP_INIT) begin
            init_d = 1'b1;
            lo_d   = '0;
            hi_d   = init_n;
            left_d = 1'b1;
            fc_d   = init_n;
          end else begin
            size_d = size_i;
            ord_d  = req_ord;
            row_d  = '0;
            left_d = 1'b0;
            lo_d   = '0;
            hi_d   = '0;
            if (req_bad) begin
              status_d = STATUS_BAD_SIZE;
            end
          end
        end
      end
      ST_SRCH_CHK: begin
        if (hit) begin
          off_d = found_off[PA-1:0];
          lo_d  = found_off + CW'(size_q);
          hi_d  = found_off + (CW'(1) << ord_q);
          fc_d  = (fc_q >= CW'(size_q)) ? (fc_q - CW'(size_q)) : '0;
        end else if (row_q == last_row) begin
          row_d = '0;
          if (ord_q == TOP_ORD) begin
            status_d = STATUS_NO_SPACE;
            off_d    = '0;
          end else begin
            ord_d = ord_q + OW'(1);
          end
        end else begin
          row_d = row_q + RW'(1);
        end
      end
      ST_CARVE_RD: begin
        if (lo_q < hi_q) begin
          mark_addr_d = mark_addr;
          mark_bit_d  = midx[ROW_LOG-1:0];
          if (left_q) begin
            lo_d = lo_q + p_size;
          end else begin
            hi_d = hi_q - p_size;
          end
        end
      end
      ST_DONE: init_d = 1'b0;
      default: init_d = init_q;
    endcase
  end

  // Registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      init_q      <= 1'b0;
      clr_q       <= '0;
      lo_q        <= '0;
      hi_q        <= '0;
      left_q      <= 1'b0;
      ord_q       <= '0;
      row_q       <= '0;
      size_q      <= '0;
      mark_addr_q <= '0;
      mark_bit_q  <= '0;
      fc_q        <= '0;
      off_q       <= '0;
      status_q    <= STATUS_OK;
    end else begin
      state_q     <= state_d;
      init_q      <= init_d;
      clr_q       <= clr_d;
      lo_q        <= lo_d;
      hi_q        <= hi_d;
      left_q      <= left_d;
      ord_q       <= ord_d;
      row_q       <= row_d;
      size_q      <= size_d;
      mark_addr_q <= mark_addr_d;
      mark_bit_q  <= mark_bit_d;
      fc_q        <= fc_d;
      off_q       <= off_d;
      status_q    <= status_d;
    end
  end

  assign flags_o.ready = (state_q == ST_IDLE);
  assign flags_o.done  = (state_q == ST_DONE) && slot_free_i;
  assign status_o      = status_q;
  assign offset_o      = off_q;
  assign free_pages_o  = fc_q;

  // The free count never exceeds the managed space.
  `PPA_ASSERT_HOLD(a_fc_bound, fc_q <= PAGES_CNT, "free page count above page space")
  // A carve piece never overshoots the end of its range.
  `PPA_ASSERT_IMPL(a_carve_range, state_q == ST_CARVE_WR, lo_q <= hi_q, "carve range inverted")
  // A failed item always reports offset zero.
  `PPA_ASSERT_IMPL(a_fail_off, state_q == ST_DONE && status_q != STATUS_OK, off_q == '0,
                   "nonzero offset on failed item")

endmodule

>>> hdl/power_of_two_page_allocator_unit.sv
// Top level of the power-of-two page allocator: handshakes, configuration, result register.
// Depends on ppa_pkg and ppa_ctrl.
//
//   channel  direction  handshake                  payload
//   in       input      in_valid_i / in_ready_o    opcode_i, pages_requested_i
//   out      output     out_valid_o / out_ready_i  status_o, page_offset_o, free_pages_o
//   cfg      input      cfg_valid_i / cfg_ready_o  total_pages_i
//
// After reset a clearing pass zeroes the (top order + 1) * map rows used rows (160 by default)
// of the map RAM; no item is taken meanwhile.
// Init: the same clearing pass, then a map read and a map write per carved block.
// Alloc: a read and a check per map row scanned (up to 62 rows by default), a read and a
// write per piece returned; each map update passes through the RAM's registered read.
// A finished result waits in the output register; the next item is taken meanwhile.
module power_of_two_page_allocator_unit
  import ppa_pkg::*;
#(
  parameter int PAGE_ADDR_BITS = PAGE_ADDR_BITS_DEF,
  parameter int MAX_ORDER      = MAX_ORDER_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic                      opcode_i,
  input  logic [SIZE_W-1:0]         pages_requested_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [1:0]                status_o,
  output logic [PAGE_ADDR_BITS-1:0] page_offset_o,
  output logic [PAGE_ADDR_BITS:0]   free_pages_o,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [CFG_W-1:0]          total_pages_i
);

  localparam int CW = PAGE_ADDR_BITS + 1;

  ppa_ctrl_flags_t           flags;
  ppa_status_e               ctrl_status;
  logic [PAGE_ADDR_BITS-1:0] ctrl_offset;
  logic [CW-1:0]             ctrl_free;
  logic                      slot_free;

  logic [CFG_W-1:0]          total_q;
  logic                      out_valid_q;
  ppa_status_e               status_q;
  logic [PAGE_ADDR_BITS-1:0] offset_q;
  logic [CW-1:0]             free_q;

  assign slot_free = !out_valid_q || out_ready_i;

  ppa_ctrl #(
    .PAGE_ADDR_BITS(PAGE_ADDR_BITS),
    .MAX_ORDER     (MAX_ORDER)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (in_valid_i && flags.ready),
    .opcode_i     (opcode_i),
    .size_i       (pages_requested_i),
    .total_pages_i(total_q),
    .slot_free_i  (slot_free),
    .flags_o      (flags),
    .status_o     (ctrl_status),
    .offset_o     (ctrl_offset),
    .free_pages_o (ctrl_free)
  );

  // Configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= TOTAL_PAGES_RST;
    end else if (cfg_valid_i) begin
      total_q <= total_pages_i;
    end
  end

  // Result register: loaded when an item finishes, emptied when the beat is taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (flags.done) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (flags.done) begin
      status_q <= ctrl_status;
      offset_q <= ctrl_offset;
      free_q   <= ctrl_free;
    end
  end

  assign in_ready_o    = flags.ready;
  assign cfg_ready_o   = 1'b1;
  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign page_offset_o = offset_q;
  assign free_pages_o  = free_q;

endmodule
